// ===== hdl/cclpg_pkg.sv =====
// Package for the character cell line pixel generator.
// Holds field widths, register and request codes, and the foreground color decode.
// No dependencies.
package cclpg_pkg;

  // Geometry
  localparam int PIXELS_PER_CHAR = 6;
  localparam int GLYPH_ROWS      = 8;
  localparam int MAX_LINES       = 16;

  localparam int COLOR_W    = 3;
  localparam int PIXELS_W   = PIXELS_PER_CHAR * COLOR_W;
  localparam int CODE_W     = 8;
  localparam int LINE_W     = 4;
  localparam int FONT_W     = 8;
  localparam int LPR_W      = 5;
  localparam int ATTR_W     = 4;
  localparam int ROW_W      = $clog2(GLYPH_ROWS);
  localparam int FONT_AW    = CODE_W + ROW_W;
  localparam int FONT_DEPTH = 256 * GLYPH_ROWS;
  localparam int FLAG_IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  // Attribute bit positions
  localparam int ATTR_RVV  = 0;
  localparam int ATTR_HGLT = 1;
  localparam int ATTR_GPA0 = 2;
  localparam int ATTR_GPA1 = 3;

  // Dashed underline check looks at this font bit
  localparam int DASH_FONT_BIT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE     = 3'd0,
    CFG_HGLT_FROM_NEXT = 3'd1,
    CFG_GPA_FROM_NEXT  = 3'd2,
    CFG_RVV_FROM_NEXT  = 3'd3,
    CFG_LTEN_FROM_NEXT = 3'd4
  } cfg_idx_e;

  typedef enum logic [COLOR_W-1:0] {
    MODE_ORIG_MONO = 3'd0,
    MODE_MONO      = 3'd1,
    MODE_COLOR1    = 3'd2,
    MODE_COLOR2    = 3'd3,
    MODE_COLOR3    = 3'd4
  } color_mode_e;

  typedef enum logic {
    REQ_FONT_WRITE = 1'b0,
    REQ_RENDER     = 1'b1
  } req_type_e;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 3'b111;
  localparam logic [COLOR_W-1:0] COLOR_MONO  = 3'b001;

  // Foreground color for the current mode; undefined modes act as mono
  function automatic logic [COLOR_W-1:0] fg_color(logic [COLOR_W-1:0] mode,
                                                  logic gpa0, logic gpa1,
                                                  logic hglt);
    logic [COLOR_W-1:0] c;
    c = COLOR_MONO;
    case (mode)
      MODE_COLOR1: begin
        c = {gpa1, gpa0, hglt};
        if (c == '0) c = COLOR_WHITE;
      end
      MODE_COLOR2: c = {~hglt, ~gpa1, ~gpa0};
      MODE_COLOR3: c = {~gpa0, ~gpa1, ~hglt};
      default:     c = COLOR_MONO;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/cclpg_if.sv =====
// Valid/ready channel interfaces for the character cell line pixel generator.
// Depends on cclpg_pkg for field widths.
interface cclpg_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [cclpg_pkg::CODE_W-1:0]  char_code;
  logic [cclpg_pkg::LINE_W-1:0]  line_index;
  logic [cclpg_pkg::FONT_W-1:0]  font_data;
  logic [cclpg_pkg::LPR_W-1:0]   lines_per_row;
  logic                          offset_line_mode;
  logic                          vsp;
  logic                          lten_cur;
  logic                          lten_next;
  logic [cclpg_pkg::ATTR_W-1:0]  attr_cur;
  logic [cclpg_pkg::ATTR_W-1:0]  attr_next;
  logic                          row_start;

  modport source (output valid, req_type, char_code, line_index, font_data, lines_per_row,
                  offset_line_mode, vsp, lten_cur, lten_next, attr_cur, attr_next,
                  row_start, input ready);
  modport sink (input valid, req_type, char_code, line_index, font_data, lines_per_row,
                offset_line_mode, vsp, lten_cur, lten_next, attr_cur, attr_next,
                row_start, output ready);
endinterface

interface cclpg_out_if;
  logic                           valid;
  logic                           ready;
  logic [cclpg_pkg::PIXELS_W-1:0] pixels;

  modport source (output valid, pixels, input ready);
  modport sink (input valid, pixels, output ready);
endinterface

// ===== hdl/char_cell_line_pixel_generator_unit.sv =====
// Character cell line pixel generator: font store plus one-line cell renderer.
// Depends on cclpg_pkg and the channel interfaces in cclpg_if.sv.
// Pipeline: a render request passes through the stage 1 register, then the result register.
// Throughput: one request per cycle unless the result side stalls; the font store has one port, used by
//   the request being accepted (write or read), with registered read data.
// Reset: config registers take their defaults, dashed flags and valids clear;
//   the font store is not cleared and holds garbage until written.
module char_cell_line_pixel_generator_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cclpg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cclpg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  cclpg_in_if.sink                        req_i,
  cclpg_out_if.source                     res_o
);

  typedef struct packed {
    logic                         req_type;
    logic [cclpg_pkg::LINE_W-1:0] line_index;
    logic                         vsp;
    logic                         lten_cur;
    logic                         lten_next;
    logic [cclpg_pkg::ATTR_W-1:0] attr_cur;
    logic [cclpg_pkg::ATTR_W-1:0] attr_next;
    logic                         row_start;
  } stage_t;

  // Config registers
  logic [cclpg_pkg::COLOR_W-1:0] color_mode_q;
  logic hglt_from_next_q, gpa_from_next_q, rvv_from_next_q, lten_from_next_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q     <= cclpg_pkg::MODE_MONO;
      hglt_from_next_q <= 1'b1;
      gpa_from_next_q  <= 1'b1;
      rvv_from_next_q  <= 1'b0;
      lten_from_next_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cclpg_pkg::cfg_idx_e'(cfg_idx_i))
        cclpg_pkg::CFG_COLOR_MODE:     color_mode_q     <= cfg_data_i;
        cclpg_pkg::CFG_HGLT_FROM_NEXT: hglt_from_next_q <= cfg_data_i[0];
        cclpg_pkg::CFG_GPA_FROM_NEXT:  gpa_from_next_q  <= cfg_data_i[0];
        cclpg_pkg::CFG_RVV_FROM_NEXT:  rvv_from_next_q  <= cfg_data_i[0];
        cclpg_pkg::CFG_LTEN_FROM_NEXT: lten_from_next_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic s1_valid_q, res_valid_q;
  logic accept, s1_adv;

  assign s1_adv      = s1_valid_q && (!res_valid_q || res_o.ready);
  assign req_i.ready = !s1_valid_q || !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Glyph row: for renders the line counter, lagging by one in offset line mode; font writes use the line index
  logic [cclpg_pkg::LPR_W-1:0] lc_wide;
  logic [cclpg_pkg::ROW_W-1:0] row;

  always_comb begin
    if (!req_i.offset_line_mode) begin
      lc_wide = {1'b0, req_i.line_index};
    end else if (req_i.line_index != '0) begin
      lc_wide = {1'b0, req_i.line_index} - cclpg_pkg::LPR_W'(1);
    end else begin
      lc_wide = req_i.lines_per_row - cclpg_pkg::LPR_W'(1);
    end
    if (req_i.req_type == cclpg_pkg::REQ_FONT_WRITE) begin
      row = req_i.line_index[cclpg_pkg::ROW_W-1:0];
    end else begin
      row = lc_wide[cclpg_pkg::ROW_W-1:0];
    end
  end

  // Font store: one port, written or read by the accepted request
  logic [cclpg_pkg::FONT_W-1:0] font_mem [cclpg_pkg::FONT_DEPTH];
  logic [cclpg_pkg::FONT_W-1:0] font_q;
  logic [cclpg_pkg::FONT_AW-1:0] font_addr;

  assign font_addr = {req_i.char_code, row};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (req_i.req_type == cclpg_pkg::REQ_FONT_WRITE) begin
        font_mem[font_addr] <= req_i.font_data;
      end
      font_q <= font_mem[font_addr];
    end
  end

  // Stage 1 register
  stage_t s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.req_type   <= req_i.req_type;
      s1_q.line_index <= req_i.line_index;
      s1_q.vsp        <= req_i.vsp;
      s1_q.lten_cur   <= req_i.lten_cur;
      s1_q.lten_next  <= req_i.lten_next;
      s1_q.attr_cur   <= req_i.attr_cur;
      s1_q.attr_next  <= req_i.attr_next;
      s1_q.row_start  <= req_i.row_start;
    end
  end

  // Attribute selection and color
  logic [cclpg_pkg::ATTR_W-1:0] a_h, a_g, a_r;
  logic lten, rvv, dashed, invert;
  logic [cclpg_pkg::COLOR_W-1:0] fg;

  assign a_h    = hglt_from_next_q ? s1_q.attr_next : s1_q.attr_cur;
  assign a_g    = gpa_from_next_q ? s1_q.attr_next : s1_q.attr_cur;
  assign a_r    = rvv_from_next_q ? s1_q.attr_next : s1_q.attr_cur;
  assign lten   = lten_from_next_q ? s1_q.lten_next : s1_q.lten_cur;
  assign rvv    = a_r[cclpg_pkg::ATTR_RVV];
  assign dashed = (color_mode_q == cclpg_pkg::MODE_ORIG_MONO);
  assign invert = rvv && !dashed;
  assign fg     = cclpg_pkg::fg_color(color_mode_q, a_g[cclpg_pkg::ATTR_GPA0],
                                      a_g[cclpg_pkg::ATTR_GPA1], a_h[cclpg_pkg::ATTR_HGLT]);

  // Dashed underline flags, one per scan line
  logic [cclpg_pkg::MAX_LINES-1:0]  flags_q, flags_d, flags_clr;
  logic [cclpg_pkg::FLAG_IDX_W-1:0] fi;
  logic                             flag;
  logic                             is_render;

  assign is_render = (s1_q.req_type == cclpg_pkg::REQ_RENDER);
  assign fi        = s1_q.line_index[cclpg_pkg::FLAG_IDX_W-1:0];
  assign flags_clr = s1_q.row_start ? '0 : flags_q;
  assign flag      = dashed ? (lten && !flags_clr[fi]) : lten;

  always_comb begin
    flags_d = flags_clr;
    if (is_render) begin
      flags_d[fi] = dashed ? (flag || !(s1_q.vsp || font_q[cclpg_pkg::DASH_FONT_BIT]))
                           : flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (s1_adv) begin
      flags_q <= flags_d;
    end
  end

  // Pixel row: slot k uses font bit k, leftmost pixel in the top slot
  logic [cclpg_pkg::PIXELS_W-1:0] pixels_d;

  always_comb begin
    logic v;
    pixels_d = '0;
    for (int k = 0; k < cclpg_pkg::PIXELS_PER_CHAR; k++) begin
      v = flag || !(s1_q.vsp || font_q[k]);
      if (invert) v = !v;
      pixels_d[k*cclpg_pkg::COLOR_W +: cclpg_pkg::COLOR_W] = v ? fg : '0;
    end
  end

  // Result register
  logic [cclpg_pkg::PIXELS_W-1:0] pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (s1_adv) begin
      res_valid_q <= is_render;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && is_render) begin
      pixels_q <= pixels_d;
    end
  end

  assign res_o.valid  = res_valid_q;
  assign res_o.pixels = pixels_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for char_cell_line_pixel_generator_unit.
// Drives font writes and cell-line renders on the valid/ready request channel and checks
// each pixel line against an in-bench predictor. Depends on cclpg_pkg and cclpg_if.sv.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cclpg_pkg::*;

  // One request on the input channel
  typedef struct {
    req_type_e           req;
    logic [CODE_W-1:0]   code;
    logic [LINE_W-1:0]   line;
    logic [FONT_W-1:0]   fdata;
    logic [LPR_W-1:0]    lpr;
    logic                offs;
    logic                vsp;
    logic                lten_c;
    logic                lten_n;
    logic [ATTR_W-1:0]   a_cur;
    logic [ATTR_W-1:0]   a_nxt;
    logic                rs;
  } cell_req_t;

  // Full register setting: mode plus the four from-next selects
  typedef struct packed {
    logic [COLOR_W-1:0] mode;
    logic               hglt;
    logic               gpa;
    logic               rvv;
    logic               lten;
  } cfg_set_t;

  // Directed row: register setting, request, and an optional typed-in result
  typedef struct {
    cfg_set_t            cfg;
    cell_req_t           rq;
    bit                  typed;
    logic [PIXELS_W-1:0] pix;
  } dir_row_t;

  localparam logic [COLOR_W-1:0] MODE_UNDEF = 3'd7;

  localparam cfg_set_t CS_RESET = '{MODE_MONO,      1'b1, 1'b1, 1'b0, 1'b0};
  localparam cfg_set_t CS_C1    = '{MODE_COLOR1,    1'b1, 1'b1, 1'b0, 1'b0};
  localparam cfg_set_t CS_C2    = '{MODE_COLOR2,    1'b0, 1'b0, 1'b1, 1'b1};
  localparam cfg_set_t CS_C3    = '{MODE_COLOR3,    1'b0, 1'b0, 1'b0, 1'b0};
  localparam cfg_set_t CS_ODD   = '{MODE_UNDEF,     1'b1, 1'b1, 1'b1, 1'b1};
  localparam cfg_set_t CS_ORIG  = '{MODE_ORIG_MONO, 1'b1, 1'b1, 1'b0, 1'b0};

  localparam logic [PIXELS_W-1:0] PIX_DARK  = '0;
  localparam logic [PIXELS_W-1:0] PIX_MONO  = 18'o111111;
  localparam logic [PIXELS_W-1:0] PIX_WHITE = 18'o777777;

  localparam int N_PHASES        = 10;
  localparam int ITEMS_PER_PHASE = 145;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  cfg_idx_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  cclpg_in_if  req_if ();
  cclpg_out_if res_if ();

  char_cell_line_pixel_generator_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .req_i     (req_if),
    .res_o     (res_if)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [FONT_W-1:0]    glyph_mem [FONT_DEPTH];
  bit                   glyph_written [FONT_DEPTH];
  logic [CODE_W-1:0]    glyph_pool [$];
  logic [MAX_LINES-1:0] dash_flags = '0;
  logic [COLOR_W-1:0]   mode_q = MODE_MONO;
  logic                 hglt_nx = 1'b1;
  logic                 gpa_nx = 1'b1;
  logic                 rvv_nx = 1'b0;
  logic                 lten_nx = 1'b0;
  cfg_set_t             applied = CS_RESET;

  logic [PIXELS_W-1:0]  exp_pixels_q [$];
  int                   err_cnt = 0;
  bit                   idle_on = 1'b1;

  // Directed stimulus: reset settings, extremes, offset wrap, every mode, dashed underline
  dir_row_t dir_rows [25] = '{
    '{CS_RESET, '{REQ_FONT_WRITE, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b1}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_FONT_WRITE, 8'hFF, 4'd15, 8'hFF, 5'd16, 1'b1, 1'b1, 1'b1, 1'b1,
                  4'hF, 4'hF, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_FONT_WRITE, 8'h41, 4'd3, 8'h5A, 5'd1, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_MONO},
    '{CS_RESET, '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'hF, 1'b0}, 1'b1, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b1, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_MONO},
    '{CS_RESET, '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b1, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h1, 4'h0, 1'b0}, 1'b1, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h1, 1'b0}, 1'b1, PIX_MONO},
    '{CS_RESET, '{REQ_RENDER, 8'hFF, 4'd0, 8'h00, 5'd16, 1'b1, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'hFF, 4'd0, 8'h00, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h00, 4'd1, 8'h00, 5'd8, 1'b1, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h41, 4'd11, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_RESET, '{REQ_RENDER, 8'h41, 4'd4, 8'h00, 5'd5, 1'b1, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_C1,    '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_WHITE},
    '{CS_C1,    '{REQ_RENDER, 8'h41, 4'd3, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'hB, 4'h4, 1'b0}, 1'b0, PIX_DARK},
    '{CS_C2,    '{REQ_RENDER, 8'h00, 4'd0, 8'h00, 5'd8, 1'b0, 1'b1, 1'b0, 1'b1,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_WHITE},
    '{CS_C2,    '{REQ_RENDER, 8'h41, 4'd3, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h6, 4'h1, 1'b0}, 1'b0, PIX_DARK},
    '{CS_C3,    '{REQ_RENDER, 8'h41, 4'd3, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h9, 4'h0, 1'b0}, 1'b0, PIX_DARK},
    '{CS_ODD,   '{REQ_RENDER, 8'h41, 4'd3, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h1, 1'b0}, 1'b0, PIX_DARK},
    '{CS_ORIG,  '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b1, 1'b0,
                  4'h0, 4'h0, 1'b1}, 1'b1, PIX_MONO},
    '{CS_ORIG,  '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b1, 1'b0,
                  4'h1, 4'h0, 1'b0}, 1'b1, PIX_DARK},
    '{CS_ORIG,  '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b1, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_MONO},
    '{CS_ORIG,  '{REQ_FONT_WRITE, 8'h00, 4'd5, 8'h00, 5'd8, 1'b0, 1'b0, 1'b0, 1'b0,
                  4'h0, 4'h0, 1'b1}, 1'b0, PIX_DARK},
    '{CS_ORIG,  '{REQ_RENDER, 8'hFF, 4'd7, 8'h00, 5'd8, 1'b0, 1'b0, 1'b1, 1'b0,
                  4'h0, 4'h0, 1'b0}, 1'b1, PIX_MONO}
  };

  // Font address touched by a request; renders in offset mode lag one line with wrap
  function automatic logic [FONT_AW-1:0] glyph_addr(input cell_req_t r);
    logic [LPR_W-1:0] lc;
    if (r.req == REQ_FONT_WRITE || !r.offs) lc = {1'b0, r.line};
    else if (r.line != '0) lc = {1'b0, r.line} - 5'd1;
    else lc = r.lpr - 5'd1;
    return {r.code, lc[ROW_W-1:0]};
  endfunction

  // Predicts one request: updates font and dash flags, returns 1 with pixels on a render
  function automatic bit render_cell_line(input cell_req_t r,
                                          output logic [PIXELS_W-1:0] pix);
    logic [ATTR_W-1:0]     a_h, a_g, a_r;
    logic                  hglt, gpa0, gpa1, rvv, lten, flag, lit, orig;
    logic [COLOR_W-1:0]    fg;
    logic [FONT_W-1:0]     glyph;
    logic [FONT_AW-1:0]    addr;
    logic [FLAG_IDX_W-1:0] fi;
    pix = '0;
    if (r.rs) dash_flags = '0;
    addr = glyph_addr(r);
    if (r.req == REQ_FONT_WRITE) begin
      glyph_mem[addr] = r.fdata;
      glyph_written[addr] = 1'b1;
      return 1'b0;
    end
    a_h  = hglt_nx ? r.a_nxt : r.a_cur;
    a_g  = gpa_nx ? r.a_nxt : r.a_cur;
    a_r  = rvv_nx ? r.a_nxt : r.a_cur;
    hglt = a_h[ATTR_HGLT];
    gpa0 = a_g[ATTR_GPA0];
    gpa1 = a_g[ATTR_GPA1];
    rvv  = a_r[ATTR_RVV];
    lten = lten_nx ? r.lten_n : r.lten_c;
    orig = (mode_q == MODE_ORIG_MONO);
    case (mode_q)
      MODE_COLOR1: begin
        fg = {gpa1, gpa0, hglt};
        if (fg == '0) fg = COLOR_WHITE;
      end
      MODE_COLOR2: fg = {~hglt, ~gpa1, ~gpa0};
      MODE_COLOR3: fg = {~gpa0, ~gpa1, ~hglt};
      default:     fg = COLOR_MONO;
    endcase
    glyph = glyph_mem[addr];
    fi    = r.line[FLAG_IDX_W-1:0];
    flag  = orig ? (lten && !dash_flags[fi]) : lten;
    // leftmost pixel comes from the highest used font bit
    for (int p = PIXELS_PER_CHAR - 1; p >= 0; p--) begin
      lit = flag | ~(r.vsp | glyph[p]);
      if (rvv && !orig) lit = ~lit;
      pix = (pix << COLOR_W) | (lit ? fg : '0);
    end
    // dashed underline bookkeeping, looks at a fixed font bit
    if (orig && (flag || !(r.vsp || glyph[DASH_FONT_BIT]))) flag = 1'b1;
    dash_flags[fi] = flag;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Idle gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic cell_req_t rand_cell();
    cell_req_t r;
    r.req    = req_type_e'(1'($urandom_range(1)));
    r.code   = 8'($urandom_range(255));
    r.line   = 4'($urandom_range(15));
    r.fdata  = 8'($urandom_range(255));
    r.lpr    = 5'($urandom_range(16, 1));
    r.offs   = 1'($urandom_range(1));
    r.vsp    = 1'($urandom_range(1));
    r.lten_c = 1'($urandom_range(1));
    r.lten_n = 1'($urandom_range(1));
    r.a_cur  = 4'($urandom_range(15));
    r.a_nxt  = 4'($urandom_range(15));
    r.rs     = ($urandom_range(15) == 0);
    return r;
  endfunction

  // Present one request, hold it until accepted, then predict its result
  task automatic send_req(input cell_req_t r, input bit typed,
                          input logic [PIXELS_W-1:0] typed_pix);
    int                  gap;
    bit                  has_res;
    logic [PIXELS_W-1:0] pix;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.req_type         <= r.req;
    req_if.char_code        <= r.code;
    req_if.line_index       <= r.line;
    req_if.font_data        <= r.fdata;
    req_if.lines_per_row    <= r.lpr;
    req_if.offset_line_mode <= r.offs;
    req_if.vsp              <= r.vsp;
    req_if.lten_cur         <= r.lten_c;
    req_if.lten_next        <= r.lten_n;
    req_if.attr_cur         <= r.a_cur;
    req_if.attr_next        <= r.a_nxt;
    req_if.row_start        <= r.rs;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    has_res = render_cell_line(r, pix);
    if (has_res) exp_pixels_q.push_back(typed ? typed_pix : pix);
  endtask

  // Wait for all pixel lines to drain plus the pipeline depth
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (exp_pixels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_put(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_COLOR_MODE:     mode_q  = val;
      CFG_HGLT_FROM_NEXT: hglt_nx = val[0];
      CFG_GPA_FROM_NEXT:  gpa_nx  = val[0];
      CFG_RVV_FROM_NEXT:  rvv_nx  = val[0];
      CFG_LTEN_FROM_NEXT: lten_nx = val[0];
      default: ;
    endcase
  endtask

  // Write every register back to back while the block is idle
  task automatic apply_config(input cfg_set_t c);
    wait_idle();
    cfg_put(CFG_COLOR_MODE, c.mode);
    cfg_put(CFG_HGLT_FROM_NEXT, {2'b00, c.hglt});
    cfg_put(CFG_GPA_FROM_NEXT, {2'b00, c.gpa});
    cfg_put(CFG_RVV_FROM_NEXT, {2'b00, c.rvv});
    cfg_put(CFG_LTEN_FROM_NEXT, {2'b00, c.lten});
    cfg_we  <= 1'b0;
    applied = c;
  endtask

  // Fill all glyph rows of one code so row sequences may render it
  task automatic write_glyph(input logic [CODE_W-1:0] code);
    cell_req_t r;
    for (int row = 0; row < GLYPH_ROWS; row++) begin
      r       = rand_cell();
      r.req   = REQ_FONT_WRITE;
      r.code  = code;
      r.line  = {1'($urandom_range(1)), 3'(row)};
      send_req(r, 1'b0, '0);
    end
    if (!(code inside {glyph_pool})) glyph_pool.push_back(code);
  endtask

  // Stimulus
  initial begin : stimulus
    cell_req_t          r;
    cfg_set_t           c;
    int                 n;
    int                 lpr;
    bit                 offs;
    logic [FONT_AW-1:0] ga;
    req_if.valid            <= 1'b0;
    req_if.req_type         <= REQ_FONT_WRITE;
    req_if.char_code        <= '0;
    req_if.line_index       <= '0;
    req_if.font_data        <= '0;
    req_if.lines_per_row    <= '0;
    req_if.offset_line_mode <= 1'b0;
    req_if.vsp              <= 1'b0;
    req_if.lten_cur         <= 1'b0;
    req_if.lten_next        <= 1'b0;
    req_if.attr_cur         <= '0;
    req_if.attr_next        <= '0;
    req_if.row_start        <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_idx                 <= CFG_COLOR_MODE;
    cfg_data                <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, first ones under the reset register values
    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg != applied) apply_config(dir_rows[i].cfg);
      send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].pix);
    end

    // random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      c.mode = (p < 5) ? 3'(p) : (p == 8) ? MODE_UNDEF : 3'($urandom_range(4));
      if (p == 0) {c.hglt, c.gpa, c.rvv, c.lten} = 4'b0000;
      else if (p == 1) {c.hglt, c.gpa, c.rvv, c.lten} = 4'b1111;
      else {c.hglt, c.gpa, c.rvv, c.lten} = 4'($urandom_range(15));
      apply_config(c);
      idle_on = (p % 3 != 2);
      write_glyph(8'($urandom_range(255)));
      write_glyph(8'($urandom_range(255)));
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 70) begin
          // well-formed character row: row start, then lines in order
          lpr  = ($urandom_range(9) == 0) ? $urandom_range(4, 1) : $urandom_range(16, 8);
          offs = 1'($urandom_range(1));
          for (int ln = 0; ln < lpr; ln++) begin
            r        = rand_cell();
            r.req    = REQ_RENDER;
            r.code   = glyph_pool[$urandom_range(glyph_pool.size() - 1)];
            r.line   = 4'(ln);
            r.lpr    = 5'(lpr);
            r.offs   = offs;
            r.vsp    = ($urandom_range(7) == 0);
            r.lten_c = ($urandom_range(3) == 0);
            r.lten_n = ($urandom_range(3) == 0);
            r.rs     = (ln == 0);
            send_req(r, 1'b0, '0);
            n++;
          end
        end else begin
          // noise; a render of a never-written font byte becomes that write
          r  = rand_cell();
          ga = glyph_addr(r);
          if (r.req == REQ_RENDER && !glyph_written[ga]) begin
            r.line = {r.line[LINE_W-1], ga[ROW_W-1:0]};
            r.req  = REQ_FONT_WRITE;
          end
          send_req(r, 1'b0, '0);
          n++;
        end
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && exp_pixels_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side backpressure
  initial begin : res_stall
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  // Compare each delivered pixel line with the oldest prediction
  always @(posedge clk) begin : pixel_check
    logic [PIXELS_W-1:0] want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (exp_pixels_q.size() == 0) begin
        report_mismatch($sformatf("pixel line %h with none pending", res_if.pixels));
      end else begin
        want = exp_pixels_q.pop_front();
        if (res_if.pixels !== want)
          report_mismatch($sformatf("pixels got %h want %h", res_if.pixels, want));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== char_cell_line_pixel_generator_unit.f =====
hdl/cclpg_pkg.sv
hdl/cclpg_if.sv
hdl/char_cell_line_pixel_generator_unit.sv
tb/tb_top.sv
